// File: rtl/ffcp_pkg.sv
`timescale 1ns / 1ps
// ffcp_pkg: types and constants for the first-fit counter packer
// no dependencies; used by every module of the block but ffcp_ram

package ffcp_pkg;

  localparam int TIME_W = 30;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [TIME_W-1:0] CAPACITY_RESET = 30'd1000000000;

  // register index, taken from paddr[2]
  localparam logic REG_COUNTER_CAPACITY = 1'b0;

  localparam logic [STAT_W-1:0] ST_PLACED     = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_BIG    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_COUNTER = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] service_time;
    logic              first_of_set;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  counter_index;
    logic [CNT_W-1:0]  counters_in_use;
    logic [STAT_W-1:0] status;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic place_zero;
    logic flag_big;
    logic flag_full;
    logic open_new;
    logic start_scan;
    logic scan;
    logic place_hit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic too_big;
    logic none_open;
    logic hit;
    logic last;
    logic full;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/ffcp_ram.sv
`timescale 1ns / 1ps
// ffcp_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies

module ffcp_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ffcp_datapath.sv
`timescale 1ns / 1ps
// ffcp_datapath: capacity register, budget ram, scan pointers, result and output registers
// depends on ffcp_pkg and ffcp_ram

module ffcp_datapath #(
  parameter int NUM_COUNTERS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ffcp_pkg::in_t               in_data,
  input  ffcp_pkg::cmd_t              cmd,
  output ffcp_pkg::stat_t             stat,
  input  logic                        cap_we,
  input  logic [ffcp_pkg::TIME_W-1:0] cap_wdata,
  output logic [ffcp_pkg::TIME_W-1:0] cap_value,
  output ffcp_pkg::out_t              out_data,
  output logic                        out_valid,
  input  logic                        out_ready
);

  localparam int AW = NUM_COUNTERS > 1 ? $clog2(NUM_COUNTERS) : 1;
  localparam int CW = $clog2(NUM_COUNTERS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_COUNTERS);

  logic [ffcp_pkg::TIME_W-1:0] t_r;
  logic [ffcp_pkg::TIME_W-1:0] cap_r;
  logic [CW-1:0]               opened_r;
  logic [CW-1:0]               opened_inc;
  logic [CW-1:0]               rd_k_r;
  logic [AW-1:0]               cmp_k_r;
  logic                        cmp_vld_r;
  ffcp_pkg::out_t              res_r;
  ffcp_pkg::out_t              out_r;
  logic                        out_valid_r;

  logic                        rd_issue;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [ffcp_pkg::TIME_W-1:0] mem_wdata;
  logic [ffcp_pkg::TIME_W-1:0] mem_rdata;

  assign opened_inc = opened_r + 1'b1;
  assign rd_issue   = cmd.scan && (rd_k_r < opened_r);
  assign mem_we     = cmd.place_hit || cmd.open_new;
  assign mem_waddr  = cmd.place_hit ? cmp_k_r : opened_r[AW-1:0];
  assign mem_wdata  = cmd.place_hit ? (mem_rdata - t_r) : (cap_r - t_r);

  ffcp_ram #(
    .WIDTH(ffcp_pkg::TIME_W),
    .DEPTH(NUM_COUNTERS)
  ) u_budget_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (rd_issue),
    .raddr(rd_k_r[AW-1:0]),
    .rdata(mem_rdata)
  );

  always_comb begin
    stat.zero      = (t_r == '0);
    stat.too_big   = (t_r > cap_r);
    stat.none_open = (opened_r == '0);
    stat.hit       = cmp_vld_r && (mem_rdata >= t_r);
    stat.last      = cmp_vld_r && (CW'(cmp_k_r) == (opened_r - 1'b1));
    stat.full      = (opened_r == FULL_COUNT);
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= ffcp_pkg::CAPACITY_RESET;
    end else if (cap_we) begin
      cap_r <= cap_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opened_r <= '0;
    end else if (cmd.load && in_data.first_of_set) begin
      opened_r <= '0;
    end else if (cmd.open_new) begin
      opened_r <= opened_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r <= in_data.service_time;
    end
  end

  // scan pointers: read index runs one ahead of the compare index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_k_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.start_scan) begin
      rd_k_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld_r <= rd_issue;
      if (rd_issue) begin
        rd_k_r <= rd_k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && rd_issue) begin
      cmp_k_r <= rd_k_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.place_hit) begin
      res_r.counter_index   <= ffcp_pkg::IDX_W'(cmp_k_r);
      res_r.counters_in_use <= ffcp_pkg::CNT_W'(opened_r);
      res_r.status          <= ffcp_pkg::ST_PLACED;
    end else if (cmd.open_new) begin
      res_r.counter_index   <= ffcp_pkg::IDX_W'(opened_r);
      res_r.counters_in_use <= ffcp_pkg::CNT_W'(opened_inc);
      res_r.status          <= ffcp_pkg::ST_PLACED;
    end else if (cmd.place_zero || cmd.flag_big || cmd.flag_full) begin
      res_r.counter_index   <= '0;
      res_r.counters_in_use <= ffcp_pkg::CNT_W'(opened_r);
      res_r.status          <= cmd.place_zero ? ffcp_pkg::ST_PLACED :
                               cmd.flag_big   ? ffcp_pkg::ST_TOO_BIG :
                                                ffcp_pkg::ST_NO_COUNTER;
    end else begin
      res_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= res_r;
    end
  end

  assign cap_value = cap_r;
  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

// File: rtl/ffcp_ctrl.sv
`timescale 1ns / 1ps
// ffcp_ctrl: state machine that sequences check, scan and result hand-off
// depends on ffcp_pkg

module ffcp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffcp_pkg::stat_t stat,
  output ffcp_pkg::cmd_t  cmd
);

  ffcp_pkg::fsm_state_t state_r;
  ffcp_pkg::fsm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffcp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffcp_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = ffcp_pkg::S_CHECK;
        end
      end
      ffcp_pkg::S_CHECK: begin
        priority if (stat.zero || stat.too_big || stat.none_open) begin
          state_nxt = ffcp_pkg::S_FINISH;
        end else begin
          state_nxt = ffcp_pkg::S_SCAN;
        end
      end
      ffcp_pkg::S_SCAN: begin
        if (stat.hit || stat.last) begin
          state_nxt = ffcp_pkg::S_FINISH;
        end
      end
      ffcp_pkg::S_FINISH: begin
        if (stat.out_free) begin
          state_nxt = ffcp_pkg::S_IDLE;
        end
      end
      default: state_nxt = ffcp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ffcp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ffcp_pkg::S_CHECK: begin
        priority if (stat.zero) begin
          cmd.place_zero = 1'b1;
        end else if (stat.too_big) begin
          cmd.flag_big = 1'b1;
        end else if (stat.none_open) begin
          cmd.open_new = 1'b1;
        end else begin
          cmd.start_scan = 1'b1;
        end
      end
      ffcp_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        priority if (stat.hit) begin
          cmd.place_hit = 1'b1;
        end else if (stat.last && stat.full) begin
          cmd.flag_full = 1'b1;
        end else if (stat.last) begin
          cmd.open_new = 1'b1;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ffcp_pkg::S_FINISH: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/first_fit_counter_packer.sv
`timescale 1ns / 1ps
// first_fit_counter_packer: top level, apb register port, controller and datapath
// a zero, oversized or first-counter request is settled in the check state; any other request
// is scanned against the opened counters in order until one fits or the last one is seen
// one request at a time, taken only while idle, the scan reading one budget ram entry a cycle;
// reset is synchronous active low, no clearing pass
// depends on ffcp_pkg, ffcp_ctrl, ffcp_datapath, ffcp_ram

module first_fit_counter_packer #(
  parameter int NUM_COUNTERS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ffcp_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ffcp_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffcp_pkg::ADDR_W-1:0]   paddr,
  input  logic [ffcp_pkg::DATA_W-1:0]   pwdata,
  output logic [ffcp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  ffcp_pkg::cmd_t              cmd;
  ffcp_pkg::stat_t             stat;
  logic                        cap_we;
  logic [ffcp_pkg::TIME_W-1:0] cap_value;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == ffcp_pkg::REG_COUNTER_CAPACITY);
  assign cap_we  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = (psel && reg_sel) ? ffcp_pkg::DATA_W'(cap_value) : '0;

  ffcp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  ffcp_datapath #(
    .NUM_COUNTERS(NUM_COUNTERS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .cap_we   (cap_we),
    .cap_wdata(pwdata[ffcp_pkg::TIME_W-1:0]),
    .cap_value(cap_value),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

endmodule

// File: rtl/ffcp_checker.sv
`timescale 1ns / 1ps
// ffcp_checker: port-level assertions for the first-fit counter packer
// depends on ffcp_pkg; bound to first_fit_counter_packer

module ffcp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ffcp_pkg::out_t out_data
);

  // one request in flight: ready drops right after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == ffcp_pkg::ST_PLACED ||
                  out_data.status == ffcp_pkg::ST_TOO_BIG ||
                  out_data.status == ffcp_pkg::ST_NO_COUNTER)
    else $error("undefined status code");

  a_unplaced_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ffcp_pkg::ST_PLACED |-> out_data.counter_index == '0)
    else $error("unplaced request carries a counter index");

endmodule

bind first_fit_counter_packer ffcp_checker u_ffcp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// File: test/tb_first_fit_counter_packer.sv
`timescale 1ns / 1ps
// tb_first_fit_counter_packer: self-checking bench for the first-fit counter packer,
// a directed table, then random customer sets with capacity changes between them
// depends on ffcp_pkg and first_fit_counter_packer; checks against table expectations and its own first-fit predictor

module tb_first_fit_counter_packer;

  localparam int NUM_COUNTERS = 1024;
  localparam int RANDOM_ITEMS = 560;
  localparam int TAIL_ITEMS   = 80;
  localparam logic [ffcp_pkg::TIME_W-1:0] CAP_MAX = 30'd1000000000;
  localparam logic [ffcp_pkg::ADDR_W-1:0] CAPACITY_ADDR =
    {ffcp_pkg::REG_COUNTER_CAPACITY, 2'b00};
  localparam bit KEEP_CAP = 1'b0;
  localparam bit NEW_CAP  = 1'b1;
  localparam bit PREDICT  = 1'b0;
  localparam bit FIXED    = 1'b1;

  typedef struct {
    bit                          new_cap;
    logic [ffcp_pkg::TIME_W-1:0] cap;
    ffcp_pkg::in_t               req;
    bit                          fixed;
    ffcp_pkg::out_t              want;
  } script_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  ffcp_pkg::in_t               in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  ffcp_pkg::out_t              out_data;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ffcp_pkg::ADDR_W-1:0] paddr = '0;
  logic [ffcp_pkg::DATA_W-1:0] pwdata = '0;
  logic [ffcp_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  // predictor state
  logic [ffcp_pkg::TIME_W-1:0] capacity_now = ffcp_pkg::CAPACITY_RESET;
  logic [ffcp_pkg::TIME_W-1:0] budget_left [NUM_COUNTERS];
  int                          opened_total = 0;

  ffcp_pkg::out_t pending_results[$];
  script_row_t    script[$];
  int             mismatches = 0;
  bit             tail_mode = 1'b0;
  int             gap_odds = 4;
  int             stall_left = 0;
  int             calm_left = 0;

  first_fit_counter_packer #(
    .NUM_COUNTERS(NUM_COUNTERS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  function automatic ffcp_pkg::out_t place_customer(input ffcp_pkg::in_t req);
    ffcp_pkg::out_t res;
    int             slot;
    bit             fit;
    res = '0;
    fit = 1'b0;
    if (req.first_of_set) begin
      opened_total = 0;
    end
    if (req.service_time == '0) begin
      res.status = ffcp_pkg::ST_PLACED;
    end else if (req.service_time > capacity_now) begin
      res.status = ffcp_pkg::ST_TOO_BIG;
    end else begin
      for (slot = 0; slot < opened_total; slot++) begin
        if (!fit && budget_left[slot] >= req.service_time) begin
          budget_left[slot] = budget_left[slot] - req.service_time;
          res.counter_index = ffcp_pkg::IDX_W'(slot);
          fit = 1'b1;
        end
      end
      if (!fit) begin
        if (opened_total < NUM_COUNTERS) begin
          res.counter_index = ffcp_pkg::IDX_W'(opened_total);
          budget_left[opened_total] = capacity_now - req.service_time;
          opened_total++;
        end else begin
          res.status = ffcp_pkg::ST_NO_COUNTER;
        end
      end
    end
    res.counters_in_use = ffcp_pkg::CNT_W'(opened_total);
    return res;
  endfunction

  task automatic send_customer(input ffcp_pkg::in_t req, input bit fixed,
                               input ffcp_pkg::out_t want);
    ffcp_pkg::out_t predicted;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = place_customer(req);
    pending_results.push_back(fixed ? want : predicted);
    if (!tail_mode && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [ffcp_pkg::TIME_W-1:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= ffcp_pkg::DATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== ffcp_pkg::DATA_W'(cap)) begin
      note_mismatch("counter_capacity readback", ffcp_pkg::DATA_W'(cap), prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    capacity_now = cap;
  endtask

  task automatic add_row(input bit new_cap, input logic [ffcp_pkg::TIME_W-1:0] cap,
                         input logic [ffcp_pkg::TIME_W-1:0] service_time,
                         input logic first_of_set,
                         input bit fixed, input ffcp_pkg::out_t want);
    script_row_t row;
    row.new_cap               = new_cap;
    row.cap                   = cap;
    row.req.service_time      = service_time;
    row.req.first_of_set      = first_of_set;
    row.fixed                 = fixed;
    row.want                  = want;
    script.push_back(row);
  endtask

  function automatic logic [ffcp_pkg::TIME_W-1:0] pick_capacity();
    case ($urandom_range(0, 4))
      0: return ffcp_pkg::TIME_W'(1);
      1: return CAP_MAX;
      2: return ffcp_pkg::TIME_W'($urandom_range(2, 100));
      3: return ffcp_pkg::TIME_W'($urandom_range(100, 100000));
      default: return ffcp_pkg::TIME_W'($urandom_range(1, CAP_MAX));
    endcase
  endfunction

  function automatic logic [ffcp_pkg::TIME_W-1:0] pick_service_time();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return capacity_now;
      2, 3: begin
        if (capacity_now < CAP_MAX) begin
          return ffcp_pkg::TIME_W'($urandom_range(capacity_now + 1, CAP_MAX));
        end else begin
          return capacity_now;
        end
      end
      4: return ffcp_pkg::TIME_W'($urandom_range(1, CAP_MAX));
      5, 6, 7, 8, 9, 10, 11: return ffcp_pkg::TIME_W'($urandom_range(1, capacity_now));
      default: return ffcp_pkg::TIME_W'($urandom_range(1, capacity_now / 4 + 1));
    endcase
  endfunction

  // output stall bursts with calm stretches between them
  always @(posedge clk) begin : ready_pattern
    if (!rst_n || tail_mode) begin
      out_ready <= 1'b1;
    end else begin
      if (calm_left == 0 && stall_left == 0 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
        if (stall_left == 0) begin
          calm_left = $urandom_range(0, 40);
        end
      end else begin
        out_ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    ffcp_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with no request pending, got %h", $realtime, out_data);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.counter_index !== want.counter_index) begin
          note_mismatch("counter_index", 32'(want.counter_index), 32'(out_data.counter_index));
        end
        if (out_data.counters_in_use !== want.counters_in_use) begin
          note_mismatch("counters_in_use", 32'(want.counters_in_use),
                        32'(out_data.counters_in_use));
        end
        if (out_data.status !== want.status) begin
          note_mismatch("status", 32'(want.status), 32'(out_data.status));
        end
      end
    end
  end

  initial begin : stimulus
    ffcp_pkg::in_t req;
    int            n;
    int            sent;
    int            set_len;

    // reset capacity first, then the extremes and the placed and too-big statuses
    add_row(KEEP_CAP, '0, 30'd0, 1'b1, FIXED, {10'd0, 11'd0, ffcp_pkg::ST_PLACED});
    add_row(KEEP_CAP, '0, 30'd1000000000, 1'b0, FIXED, {10'd0, 11'd1, ffcp_pkg::ST_PLACED});
    add_row(KEEP_CAP, '0, 30'd1, 1'b0, FIXED, {10'd1, 11'd2, ffcp_pkg::ST_PLACED});
    add_row(KEEP_CAP, '0, 30'd999999999, 1'b0, PREDICT, '0);
    add_row(KEEP_CAP, '0, 30'd0, 1'b1, FIXED, {10'd0, 11'd0, ffcp_pkg::ST_PLACED});
    add_row(NEW_CAP, 30'd1000, 30'd1001, 1'b0, FIXED, {10'd0, 11'd0, ffcp_pkg::ST_TOO_BIG});
    add_row(KEEP_CAP, '0, 30'd1000, 1'b0, PREDICT, '0);
    add_row(KEEP_CAP, '0, 30'd600, 1'b0, PREDICT, '0);
    add_row(KEEP_CAP, '0, 30'd400, 1'b0, PREDICT, '0);
    add_row(KEEP_CAP, '0, 30'd1, 1'b0, PREDICT, '0);
    // capacity lowered mid-set, old counters keep their budget
    add_row(NEW_CAP, 30'd10, 30'd500, 1'b0, FIXED, {10'd0, 11'd3, ffcp_pkg::ST_TOO_BIG});
    add_row(KEEP_CAP, '0, 30'd5, 1'b0, PREDICT, '0);
    add_row(KEEP_CAP, '0, 30'd1000000000, 1'b0, FIXED, {10'd0, 11'd3, ffcp_pkg::ST_TOO_BIG});
    add_row(NEW_CAP, 30'd1, 30'd1, 1'b1, FIXED, {10'd0, 11'd1, ffcp_pkg::ST_PLACED});
    add_row(KEEP_CAP, '0, 30'd1, 1'b0, FIXED, {10'd1, 11'd2, ffcp_pkg::ST_PLACED});
    add_row(KEEP_CAP, '0, 30'd2, 1'b0, FIXED, {10'd0, 11'd2, ffcp_pkg::ST_TOO_BIG});
    add_row(KEEP_CAP, '0, 30'd0, 1'b0, FIXED, {10'd0, 11'd2, ffcp_pkg::ST_PLACED});
    add_row(NEW_CAP, 30'd1000000000, 30'd536870912, 1'b1, FIXED,
            {10'd0, 11'd1, ffcp_pkg::ST_PLACED});
    add_row(KEEP_CAP, '0, 30'd536870911, 1'b0, PREDICT, '0);
    add_row(KEEP_CAP, '0, 30'd463129088, 1'b0, PREDICT, '0);
    add_row(KEEP_CAP, '0, 30'd0, 1'b1, PREDICT, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].new_cap) begin
        wait_results_drained();
        write_capacity(script[i].cap);
      end
      send_customer(script[i].req, script[i].fixed, script[i].want);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_results_drained();
        write_capacity(pick_capacity());
      end
      case ($urandom_range(0, 3))
        0: gap_odds = 0;
        1: gap_odds = 3;
        2: gap_odds = 6;
        default: gap_odds = 12;
      endcase
      repeat ($urandom_range(1, 4)) begin
        set_len = $urandom_range(1, 30);
        for (n = 0; n < set_len; n++) begin
          tail_mode = (sent >= RANDOM_ITEMS - TAIL_ITEMS);
          req.first_of_set = (n == 0) ? ($urandom_range(0, 9) != 0) :
                                        ($urandom_range(0, 29) == 0);
          req.service_time = pick_service_time();
          send_customer(req, PREDICT, '0);
          sent++;
        end
      end
    end

    tail_mode = 1'b1;
    wait_results_drained();
    repeat (NUM_COUNTERS + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
